>>> rtl/qcip_pkg.sv
// ----------------------------------------------------------------------------
// Quantized code inner product package
// Shared widths, request types and control structs for the lanes, the merge
// stage and the saturating accumulator.
// ----------------------------------------------------------------------------
package qcip_pkg;

  localparam int QUERY_BITS         = 16;
  localparam int CENTROID_BITS      = 16;
  localparam int SUM_BITS           = 48;
  localparam int CODE_BITS          = 4;
  localparam int NUM_CENTROIDS      = 16;
  localparam int BANK_COUNT         = 4;
  localparam int BANK_IDX_BITS      = 2;
  localparam int BANK_BITS          = 64;
  localparam int SLOT_BITS          = 16;
  localparam int SLOTS_PER_BANK     = 4;
  localparam int SLOT_IDX_BITS      = 2;
  localparam int CFG_INDEX_BITS     = 8;

  typedef struct packed {
    logic [7:0]                   code_pair;
    logic signed [QUERY_BITS-1:0] query_even;
    logic signed [QUERY_BITS-1:0] query_odd;
    logic                         odd_present;
    logic                         last_pair;
  } query_req_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] dot_total;
    logic                       saturated;
  } result_req_t;

  typedef struct packed {
    logic                     we;
    logic [BANK_IDX_BITS-1:0] bank;
    logic [BANK_BITS-1:0]     data;
  } lane_cfg_t;

  typedef struct packed {
    logic consume;
    logic last;
  } accum_ctrl_t;

endpackage

>>> rtl/qcip_lane.sv
// ----------------------------------------------------------------------------
// Quantized code inner product lane
// Holds a private copy of the centroid table, looks up the centroid for one
// code and registers the exact product with the query value.
// ----------------------------------------------------------------------------
module qcip_lane #(
  parameter int CENTROID_BITS = qcip_pkg::CENTROID_BITS,
  localparam int CW = (CENTROID_BITS > qcip_pkg::SLOT_BITS) ?
                      qcip_pkg::SLOT_BITS : CENTROID_BITS,
  localparam int PW = qcip_pkg::QUERY_BITS + CW
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  qcip_pkg::lane_cfg_t                  cfg,
  input  logic                                 load,
  input  logic [qcip_pkg::CODE_BITS-1:0]       code,
  input  logic signed [qcip_pkg::QUERY_BITS-1:0] query_value,
  input  logic                                 use_code,
  output logic signed [PW-1:0]                 product
);

  logic signed [CW-1:0] cent [qcip_pkg::NUM_CENTROIDS];
  logic signed [PW-1:0] qx;
  logic signed [PW-1:0] cx;
  logic signed [PW-1:0] mult;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < qcip_pkg::NUM_CENTROIDS; i++) begin
        cent[i] <= '0;
      end
    end else if (cfg.we) begin
      for (int j = 0; j < qcip_pkg::SLOTS_PER_BANK; j++) begin
        cent[{cfg.bank, qcip_pkg::SLOT_IDX_BITS'(j)}] <=
          cfg.data[qcip_pkg::SLOT_BITS*j +: CW];
      end
    end
  end

  assign qx   = PW'(query_value);
  assign cx   = PW'(cent[code]);
  assign mult = qx * cx;

  always_ff @(posedge clk) begin
    if (load) begin
      product <= use_code ? mult : '0;
    end
  end

endmodule

>>> rtl/qcip_merge.sv
// ----------------------------------------------------------------------------
// Quantized code inner product merge stage
// Adds the products of the even and odd lanes exactly and registers the sum.
// ----------------------------------------------------------------------------
module qcip_merge #(
  parameter int PW = qcip_pkg::QUERY_BITS + qcip_pkg::SLOT_BITS
) (
  input  logic                clk,
  input  logic                load,
  input  logic signed [PW-1:0] prod_even,
  input  logic signed [PW-1:0] prod_odd,
  output logic signed [PW:0]   pair_sum
);

  always_ff @(posedge clk) begin
    if (load) begin
      pair_sum <= (PW+1)'(prod_even) + (PW+1)'(prod_odd);
    end
  end

endmodule

>>> rtl/qcip_accum.sv
// ----------------------------------------------------------------------------
// Quantized code inner product accumulator
// Saturating running sum with a sticky clip flag and the result register.
// ----------------------------------------------------------------------------
module qcip_accum #(
  parameter int PAIR_W = qcip_pkg::QUERY_BITS + qcip_pkg::SLOT_BITS + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  qcip_pkg::accum_ctrl_t   ctrl,
  input  logic signed [PAIR_W-1:0] pair_sum,
  input  logic                    result_stall,
  output logic                    result_valid,
  output qcip_pkg::result_req_t   result
);

  localparam int S = qcip_pkg::SUM_BITS;
  localparam logic signed [S-1:0] SUM_MAX = {1'b0, {(S-1){1'b1}}};
  localparam logic signed [S-1:0] SUM_MIN = {1'b1, {(S-1){1'b0}}};

  logic signed [S-1:0] running_sum;
  logic                clip_seen;
  logic signed [S:0]   total;
  logic                clip;
  logic signed [S-1:0] sat_sum;
  logic                result_valid_next;

  assign total = (S+1)'(running_sum) + (S+1)'(pair_sum);
  assign clip  = total[S] ^ total[S-1];

  always_comb begin
    if (clip) begin
      sat_sum = total[S] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_sum = total[S-1:0];
    end
  end

  assign result_valid_next = (result_valid && result_stall) || (ctrl.consume && ctrl.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      clip_seen    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
      if (ctrl.consume) begin
        if (ctrl.last) begin
          running_sum <= '0;
          clip_seen   <= 1'b0;
        end else begin
          running_sum <= sat_sum;
          clip_seen   <= clip_seen | clip;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.consume && ctrl.last) begin
      result.dot_total <= sat_sum;
      result.saturated <= clip_seen | clip;
    end
  end

endmodule

>>> rtl/quantized_code_inner_product.sv
// ----------------------------------------------------------------------------
// Quantized code inner product
// Four-bit product-quantization lookup with a saturating fixed-point
// inner product accumulator.
// ----------------------------------------------------------------------------
// Each request carries one byte of two centroid codes and their two query
// values, and the block accepts one request every cycle unless stalled. Two
// lanes, one for the even and one for the odd coordinate, each look up a
// centroid in a private copy of the table and register its product; a merge
// stage adds the two products, and the accumulator adds that sum to the
// running total with saturation. The result passes the lane product, merge
// and result registers; the single accumulator add with its clamp is the
// loop that sets the one-request-per-cycle rate. A held result does not stop
// the pipeline until a second last request reaches the accumulator.
// Configuration writes are always taken; they must only occur while idle.
module quantized_code_inner_product #(
  parameter int CENTROID_BITS = qcip_pkg::CENTROID_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                query_valid,
  output logic                                query_stall,
  input  qcip_pkg::query_req_t                query,
  output logic                                result_valid,
  input  logic                                result_stall,
  output qcip_pkg::result_req_t               result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qcip_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [qcip_pkg::BANK_BITS-1:0]      cfg_data
);

  localparam int CW = (CENTROID_BITS > qcip_pkg::SLOT_BITS) ?
                      qcip_pkg::SLOT_BITS : CENTROID_BITS;
  localparam int PW = qcip_pkg::QUERY_BITS + CW;

  qcip_pkg::lane_cfg_t   lane_cfg;
  qcip_pkg::accum_ctrl_t acc_ctrl;

  logic                 v1;
  logic                 last1;
  logic                 v2;
  logic                 last2;
  logic                 load1;
  logic                 ready2;
  logic signed [PW-1:0] prod_even;
  logic signed [PW-1:0] prod_odd;
  logic signed [PW:0]   pair_sum;

  assign cfg_ready     = 1'b1;
  assign lane_cfg.we   = cfg_valid &&
                         (cfg_index < qcip_pkg::CFG_INDEX_BITS'(qcip_pkg::BANK_COUNT));
  assign lane_cfg.bank = cfg_index[qcip_pkg::BANK_IDX_BITS-1:0];
  assign lane_cfg.data = cfg_data;

  assign acc_ctrl.consume = v2 && (!last2 || !result_valid || !result_stall);
  assign acc_ctrl.last    = last2;
  assign ready2           = !v2 || acc_ctrl.consume;
  assign query_stall      = v1 && !ready2;
  assign load1            = !query_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (load1) begin
        v1 <= query_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      last1 <= query.last_pair;
    end
    if (ready2) begin
      last2 <= last1;
    end
  end

  qcip_lane #(
    .CENTROID_BITS(CENTROID_BITS)
  ) u_lane_even (
    .clk        (clk),
    .rst        (rst),
    .cfg        (lane_cfg),
    .load       (load1),
    .code       (query.code_pair[7:4]),
    .query_value(query.query_even),
    .use_code   (1'b1),
    .product    (prod_even)
  );

  qcip_lane #(
    .CENTROID_BITS(CENTROID_BITS)
  ) u_lane_odd (
    .clk        (clk),
    .rst        (rst),
    .cfg        (lane_cfg),
    .load       (load1),
    .code       (query.code_pair[3:0]),
    .query_value(query.query_odd),
    .use_code   (query.odd_present),
    .product    (prod_odd)
  );

  qcip_merge #(
    .PW(PW)
  ) u_merge (
    .clk      (clk),
    .load     (ready2),
    .prod_even(prod_even),
    .prod_odd (prod_odd),
    .pair_sum (pair_sum)
  );

  qcip_accum #(
    .PAIR_W(PW + 1)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (acc_ctrl),
    .pair_sum    (pair_sum),
    .result_stall(result_stall),
    .result_valid(result_valid),
    .result      (result)
  );

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(acc_ctrl.consume && acc_ctrl.last))
    else $error("result raised without a last request in the accumulator");

  a_stage2_holds: assert property (@(posedge clk) disable iff (rst)
    (v2 && !acc_ctrl.consume) |=> v2)
    else $error("request dropped from the merge stage");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (query_valid && !query_stall) |=> v1)
    else $error("accepted request not held in the lane stage");

endmodule
